/* hw/rtl/format_specifier_parser_unit_macros.svh */
// Assertion macros shared by the checker of the format specifier parser.
`ifndef FORMAT_SPECIFIER_PARSER_UNIT_MACROS_SVH
`define FORMAT_SPECIFIER_PARSER_UNIT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is held.
`define FSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define FSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/fsp_pkg.sv */
// Types, character codes and phase encoding of the format specifier parser.
`timescale 1ns / 1ps

package fsp_pkg;

  // Character codes that the parser recognises.
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_LOW_J  = 8'h6A;
  localparam logic [7:0] CH_LOW_C  = 8'h63;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_P  = 8'h70;
  localparam logic [7:0] CH_LOW_D  = 8'h64;
  localparam logic [7:0] CH_LOW_I  = 8'h69;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_PCT    = 8'h25;

  // Flag bit positions in the flag word.
  localparam logic [5:0] FLAG_MINUS = 6'b000001;
  localparam logic [5:0] FLAG_PLUS  = 6'b000010;
  localparam logic [5:0] FLAG_SPACE = 6'b000100;
  localparam logic [5:0] FLAG_ZERO  = 6'b001000;
  localparam logic [5:0] FLAG_APOS  = 6'b010000;
  localparam logic [5:0] FLAG_HASH  = 6'b100000;

  // Value of an absent width or precision, and the saturation ceiling.
  localparam logic [31:0] VAL_ABSENT = 32'hFFFF_FFFF;
  localparam logic [31:0] VAL_SAT    = 32'h7FFF_FFFF;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Length modifier codes as they leave the block.
  typedef enum logic [2:0] {
    LEN_NONE = 3'd0,
    LEN_HH   = 3'd1,
    LEN_H    = 3'd2,
    LEN_LL   = 3'd3,
    LEN_L    = 3'd4,
    LEN_BIGL = 3'd5,
    LEN_Z    = 3'd6,
    LEN_J    = 3'd7
  } len_code_t;

  // Length letter class of a character.
  typedef enum logic [2:0] {
    LT_NONE,
    LT_H,
    LT_L,
    LT_BIGL,
    LT_Z,
    LT_J
  } letter_t;

  // Parser position within the specifier.
  typedef enum logic [3:0] {
    PH_FLAGS,
    PH_WDIG,
    PH_DOT,
    PH_PSTART,
    PH_PDIG,
    PH_LEN,
    PH_LEN_H,
    PH_LEN_L,
    PH_TYPE
  } phase_t;

  // Classified character as it travels from front to back.
  typedef struct packed {
    logic [7:0]  char_byte;
    logic [31:0] star_arg;
    logic [5:0]  flag_bit;
    logic        is_digit;
    logic [3:0]  digit;
    logic        is_star;
    logic        is_dot;
    letter_t     letter;
    logic        is_type;
  } cls_word_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/fsp_front.sv */
// Front part: accepts characters and classifies each one for the parser.
`timescale 1ns / 1ps

module fsp_front import fsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic signed [31:0] in_star_arg,
  input  q_status_t   q_status,
  output logic        q_push,
  output cls_word_t   q_word
);

  logic        stall_r;
  logic        stall_nxt;
  logic [7:0]  ch;

  assign ch = in_char_byte;

  // Back-pressure follows the queue fill state, registered so that it
  // never looks at the incoming valid.
  assign stall_nxt = q_status.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_r <= 1'b1;
    end else begin
      stall_r <= stall_nxt;
    end
  end

  // The stall rises as soon as the queue is full and, through the registered
  // copy, falls only in the cycle after the queue has room again.
  assign in_stall = stall_r || q_status.full;
  assign q_push   = in_valid && !in_stall;

  // Character classification.
  always_comb begin
    q_word           = '0;
    q_word.char_byte = ch;
    q_word.star_arg  = in_star_arg;

    case (ch)
      CH_MINUS: q_word.flag_bit = FLAG_MINUS;
      CH_PLUS:  q_word.flag_bit = FLAG_PLUS;
      CH_SPACE: q_word.flag_bit = FLAG_SPACE;
      CH_ZERO:  q_word.flag_bit = FLAG_ZERO;
      CH_APOS:  q_word.flag_bit = FLAG_APOS;
      CH_HASH:  q_word.flag_bit = FLAG_HASH;
      default:  q_word.flag_bit = '0;
    endcase

    q_word.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    q_word.digit    = 4'(ch - CH_ZERO);
    q_word.is_star  = (ch == CH_STAR);
    q_word.is_dot   = (ch == CH_DOT);

    case (ch)
      CH_LOW_H: q_word.letter = LT_H;
      CH_LOW_L: q_word.letter = LT_L;
      CH_UP_L:  q_word.letter = LT_BIGL;
      CH_LOW_Z: q_word.letter = LT_Z;
      CH_LOW_J: q_word.letter = LT_J;
      default:  q_word.letter = LT_NONE;
    endcase

    q_word.is_type = ch inside {CH_LOW_C, CH_LOW_S, CH_LOW_P, CH_LOW_D, CH_LOW_I,
                                CH_LOW_U, CH_LOW_X, CH_UP_X, CH_PCT};
  end

endmodule

/* hw/rtl/fsp_queue.sv */
// Two-entry queue that decouples the classifier from the parser.
`timescale 1ns / 1ps

module fsp_queue import fsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_word_t push_word,
  input  logic      pop,
  output cls_word_t pop_word,
  output q_status_t status
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cls_word_t             entry_r [QUEUE_DEPTH];
  logic [PtrW-1:0]       wr_ptr_r;
  logic [PtrW-1:0]       wr_ptr_nxt;
  logic [PtrW-1:0]       rd_ptr_r;
  logic [PtrW-1:0]       rd_ptr_nxt;
  logic [CntW-1:0]       count_r;
  logic [CntW-1:0]       count_nxt;

  assign status.full  = (count_r == CntW'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_word     = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

/* hw/rtl/fsp_back.sv */
// Back part: the specifier phase machine, digit accumulator and result register.
`timescale 1ns / 1ps

module fsp_back import fsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_status_t   q_status,
  input  cls_word_t   q_word,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_flag_bits,
  output logic signed [31:0] out_field_width,
  output logic signed [31:0] out_precision_value,
  output logic [2:0]  out_length_code,
  output logic [7:0]  out_type_char,
  output logic        out_consumed
);

  phase_t      phase_r;
  phase_t      phase_nxt;
  phase_t      stop_ph;
  logic        emit;
  logic        step;
  logic        out_free;

  logic [5:0]  flag_r;
  logic [5:0]  flag_nxt;
  logic [31:0] width_r;
  logic [31:0] width_nxt;
  logic [31:0] prec_r;
  logic [31:0] prec_nxt;
  len_code_t   len_r;
  len_code_t   len_nxt;
  len_code_t   len_emit;

  logic [31:0] acc_base;
  logic [35:0] acc_sum;
  logic [31:0] acc_val;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [5:0]  res_flag_r;
  logic [31:0] res_width_r;
  logic [31:0] res_prec_r;
  logic [2:0]  res_len_r;
  logic [7:0]  res_type_r;
  logic        res_cons_r;

  // A word is taken unless it would end a specifier while the result
  // register is still held by the receiver.
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = !q_status.empty && (!emit || out_free);
  assign step     = q_pop;

  // Walk the fall-through chain to the phase that takes the character.
  always_comb begin : next_state
    phase_t ph;
    logic   hit;
    ph  = phase_r;
    hit = 1'b0;
    if (ph == PH_FLAGS) begin
      if ((q_word.flag_bit != '0) || q_word.is_digit || q_word.is_star) begin
        hit = 1'b1;
      end else begin
        ph = PH_DOT;
      end
    end
    if (!hit && ph == PH_WDIG) begin
      if (q_word.is_digit) begin
        hit = 1'b1;
      end else begin
        ph = PH_DOT;
      end
    end
    if (!hit && ph == PH_DOT) begin
      if (q_word.is_dot) begin
        hit = 1'b1;
      end else begin
        ph = PH_LEN;
      end
    end
    if (!hit && ph == PH_PSTART) begin
      if (q_word.is_digit || q_word.is_star) begin
        hit = 1'b1;
      end else begin
        ph = PH_LEN;
      end
    end
    if (!hit && ph == PH_PDIG) begin
      if (q_word.is_digit) begin
        hit = 1'b1;
      end else begin
        ph = PH_LEN;
      end
    end
    if (!hit && ph == PH_LEN) begin
      if (q_word.letter != LT_NONE) begin
        hit = 1'b1;
      end else begin
        ph = PH_TYPE;
      end
    end
    if (!hit && ph == PH_LEN_H) begin
      if (q_word.letter == LT_H) begin
        hit = 1'b1;
      end else begin
        ph = PH_TYPE;
      end
    end
    if (!hit && ph == PH_LEN_L) begin
      if (q_word.letter == LT_L) begin
        hit = 1'b1;
      end else begin
        ph = PH_TYPE;
      end
    end
    stop_ph = ph;
    emit    = !hit;
  end

  // Pick the phase that follows the one that took the character.
  always_comb begin : next_phase
    phase_nxt = phase_r;
    if (step) begin
      case (stop_ph)
        PH_FLAGS: begin
          if (q_word.flag_bit != '0) begin
            phase_nxt = PH_FLAGS;
          end else if (q_word.is_digit) begin
            phase_nxt = PH_WDIG;
          end else begin
            phase_nxt = PH_DOT;
          end
        end
        PH_WDIG:   phase_nxt = PH_WDIG;
        PH_DOT:    phase_nxt = PH_PSTART;
        PH_PSTART: phase_nxt = q_word.is_digit ? PH_PDIG : PH_LEN;
        PH_PDIG:   phase_nxt = PH_PDIG;
        PH_LEN: begin
          case (q_word.letter)
            LT_H:    phase_nxt = PH_LEN_H;
            LT_L:    phase_nxt = PH_LEN_L;
            default: phase_nxt = PH_TYPE;
          endcase
        end
        PH_LEN_H:  phase_nxt = PH_TYPE;
        PH_LEN_L:  phase_nxt = PH_TYPE;
        default:   phase_nxt = PH_FLAGS;
      endcase
    end
  end

  // Shared decimal accumulator: value times ten plus the digit, saturated.
  // Only one of the digit phases can take a digit in a given step.
  assign acc_base = (phase_r == PH_WDIG) ? width_r : prec_r;
  assign acc_sum  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
                    36'(q_word.digit);
  assign acc_val  = (acc_sum > 36'(VAL_SAT)) ? VAL_SAT : acc_sum[31:0];

  // A single length letter that falls through to the type position still
  // fixes the length as h or l.
  always_comb begin
    len_emit = len_r;
    if (phase_r == PH_LEN_H) begin
      len_emit = LEN_H;
    end else if (phase_r == PH_LEN_L) begin
      len_emit = LEN_L;
    end
  end

  // Field stores: update at the phase that takes the character, or clear
  // back to the reset values after a result.
  always_comb begin : field_update
    flag_nxt  = flag_r;
    width_nxt = width_r;
    prec_nxt  = prec_r;
    len_nxt   = len_r;
    if (step) begin
      case (stop_ph)
        PH_FLAGS: begin
          if (q_word.flag_bit != '0) begin
            flag_nxt = flag_r | q_word.flag_bit;
          end else if (q_word.is_digit) begin
            width_nxt = 32'(q_word.digit);
          end else begin
            width_nxt = q_word.star_arg;
          end
        end
        PH_WDIG:   width_nxt = acc_val;
        PH_DOT:    flag_nxt  = flag_r;
        PH_PSTART: prec_nxt  = q_word.is_digit ? 32'(q_word.digit) : q_word.star_arg;
        PH_PDIG:   prec_nxt  = acc_val;
        PH_LEN: begin
          case (q_word.letter)
            LT_BIGL: len_nxt = LEN_BIGL;
            LT_Z:    len_nxt = LEN_Z;
            LT_J:    len_nxt = LEN_J;
            default: len_nxt = len_r;
          endcase
        end
        PH_LEN_H:  len_nxt = LEN_HH;
        PH_LEN_L:  len_nxt = LEN_LL;
        default: begin
          flag_nxt  = '0;
          width_nxt = VAL_ABSENT;
          prec_nxt  = VAL_ABSENT;
          len_nxt   = LEN_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAGS;
      flag_r  <= '0;
      width_r <= VAL_ABSENT;
      prec_r  <= VAL_ABSENT;
      len_r   <= LEN_NONE;
    end else begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      width_r <= width_nxt;
      prec_r  <= prec_nxt;
      len_r   <= len_nxt;
    end
  end

  // Result register: loaded when a word ends a specifier, freed when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_flag_r  <= flag_r;
      res_width_r <= width_r;
      res_prec_r  <= prec_r;
      res_len_r   <= len_emit;
      res_type_r  <= q_word.is_type ? q_word.char_byte : 8'h00;
      res_cons_r  <= q_word.is_type;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_flag_bits       = res_flag_r;
  assign out_field_width     = res_width_r;
  assign out_precision_value = res_prec_r;
  assign out_length_code     = res_len_r;
  assign out_type_char       = res_type_r;
  assign out_consumed        = res_cons_r;

endmodule

/* hw/rtl/format_specifier_parser_unit.sv */
// Top level of the streaming printf format specifier parser.
`timescale 1ns / 1ps
// Usage
//   The input channel takes one character of the text that follows a percent
//   sign per word, with the star argument alongside; in_star_arg is only looked
//   at when the character is a star in the width or precision position.
//   The output channel gives one word per specifier, when a character lands in
//   the type position: flags, width, precision, length code, type character
//   and the consumed bit. All other characters produce no output word.
//   Both channels use valid and stall; a word moves when valid is high and
//   stall is low.
// Timing
//   A character is accepted every cycle while in_stall is low. The word that ends a
//   specifier goes into the two-entry queue, is read from there once the result
//   register is free, and loads the result register. The phase machine handles one
//   character per cycle while the queue is not empty and no held result blocks it.
// Reset and stalls
//   Synchronous active-low reset returns the parser to the flag phase with
//   width and precision absent, and drops out_valid.
//   While out_stall is held the result register keeps its word; characters
//   that end no specifier still drain, and the queue fills behind the one
//   that does, after which in_stall rises. It falls again in the cycle after
//   the queue has room.

module format_specifier_parser_unit import fsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic signed [31:0] in_star_arg,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_flag_bits,
  output logic signed [31:0] out_field_width,
  output logic signed [31:0] out_precision_value,
  output logic [2:0]  out_length_code,
  output logic [7:0]  out_type_char,
  output logic        out_consumed
);

  logic      q_push;
  logic      q_pop;
  cls_word_t push_word;
  cls_word_t pop_word;
  q_status_t q_status;

  // Classifier in front of the queue.
  fsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .in_star_arg  (in_star_arg),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_word       (push_word)
  );

  // Queue between classifier and parser.
  fsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .status    (q_status)
  );

  // Phase machine and result register.
  fsp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_status            (q_status),
    .q_word              (pop_word),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flag_bits       (out_flag_bits),
    .out_field_width     (out_field_width),
    .out_precision_value (out_precision_value),
    .out_length_code     (out_length_code),
    .out_type_char       (out_type_char),
    .out_consumed        (out_consumed)
  );

endmodule

/* hw/rtl/fsp_checker.sv */
// Port-level checker for the format specifier parser, bound to the top level.
`timescale 1ns / 1ps
`include "format_specifier_parser_unit_macros.svh"

module fsp_checker import fsp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_flag_bits,
  input logic [31:0] out_field_width,
  input logic [31:0] out_precision_value,
  input logic [2:0]  out_length_code,
  input logic [7:0]  out_type_char,
  input logic        out_consumed
);

  // Reset leaves no output word pending.
  `FSP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "out_valid set after reset")

  // A word held by the receiver keeps its contents.
  `FSP_ASSERT(a_hold,
    out_valid && out_stall |=> out_valid && $stable(out_flag_bits) &&
      $stable(out_field_width) && $stable(out_precision_value) &&
      $stable(out_length_code) && $stable(out_type_char) && $stable(out_consumed),
    "held output word changed")

  // An invalid type always reports a zero type character.
  `FSP_ASSERT(a_invalid_zero, out_valid && !out_consumed |-> out_type_char == 8'h00,
    "invalid type with nonzero type_char")

  // A consumed type is one of the conversion characters.
  `FSP_ASSERT(a_type_set,
    out_valid && out_consumed |-> (out_type_char == CH_LOW_C ||
      out_type_char == CH_LOW_S || out_type_char == CH_LOW_P ||
      out_type_char == CH_LOW_D || out_type_char == CH_LOW_I ||
      out_type_char == CH_LOW_U || out_type_char == CH_LOW_X ||
      out_type_char == CH_UP_X || out_type_char == CH_PCT),
    "consumed type outside the conversion set")

endmodule

bind format_specifier_parser_unit fsp_checker u_fsp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_flag_bits       (out_flag_bits),
  .out_field_width     (out_field_width),
  .out_precision_value (out_precision_value),
  .out_length_code     (out_length_code),
  .out_type_char       (out_type_char),
  .out_consumed        (out_consumed)
);

/* tb/fsp_spec_checker.sv */
// Checker that predicts and compares the result words of the format specifier parser.
`timescale 1ns / 1ps

module fsp_spec_checker import fsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic [31:0] in_star_arg,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_flag_bits,
  input  logic [31:0] out_field_width,
  input  logic [31:0] out_precision_value,
  input  logic [2:0]  out_length_code,
  input  logic [7:0]  out_type_char,
  input  logic        out_consumed,
  output int          pending_specs,
  output int          mismatch_count
);

  // One finished specifier as it should leave the block.
  typedef struct packed {
    logic [5:0]  flags;
    logic [31:0] fwidth;
    logic [31:0] prec;
    logic [2:0]  lcode;
    logic [7:0]  tchar;
    logic        consumed;
  } spec_result_t;

  // Mirror of the parser state.
  phase_t      ph;
  logic [5:0]  flg;
  logic [31:0] wid;
  logic [31:0] prc;
  len_code_t   lenc;

  spec_result_t expected_specs[$];
  int           errs;

  // Flag bit that a character sets, zero when it is no flag.
  function automatic logic [5:0] flag_of(logic [7:0] c);
    case (c)
      CH_MINUS: return FLAG_MINUS;
      CH_PLUS:  return FLAG_PLUS;
      CH_SPACE: return FLAG_SPACE;
      CH_ZERO:  return FLAG_ZERO;
      CH_APOS:  return FLAG_APOS;
      CH_HASH:  return FLAG_HASH;
      default:  return 6'd0;
    endcase
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Decimal accumulation that saturates at the largest positive value.
  function automatic logic [31:0] scale_add(logic [31:0] v, logic [7:0] c);
    logic [63:0] n;
    n = {32'd0, v} * 64'd10 + {56'd0, c - CH_ZERO};
    return (n > {32'd0, VAL_SAT}) ? VAL_SAT : n[31:0];
  endfunction

  task automatic reset_parser();
    ph   = PH_FLAGS;
    flg  = 6'd0;
    wid  = VAL_ABSENT;
    prc  = VAL_ABSENT;
    lenc = LEN_NONE;
  endtask

  // Walks one character through the positions; a character that does not fit
  // the current position falls through to the next within the same word.
  task automatic parse_spec_char(input logic [7:0] c, input logic [31:0] arg,
                                 output bit ends, output spec_result_t res);
    logic [5:0] fb;
    logic       ok;
    bit         settled;
    fb = flag_of(c);
    ends = 1'b0;
    settled = 1'b0;
    res = '0;
    while (!settled) begin
      case (ph)
        PH_FLAGS: begin
          if (fb != 6'd0) begin
            flg |= fb;
            settled = 1'b1;
          end else if (is_digit(c)) begin
            wid = {24'd0, c - CH_ZERO};
            ph = PH_WDIG;
            settled = 1'b1;
          end else if (c == CH_STAR) begin
            wid = arg;
            ph = PH_DOT;
            settled = 1'b1;
          end else begin
            ph = PH_DOT;
          end
        end
        PH_WDIG: begin
          if (is_digit(c)) begin
            wid = scale_add(wid, c);
            settled = 1'b1;
          end else begin
            ph = PH_DOT;
          end
        end
        PH_DOT: begin
          if (c == CH_DOT) begin
            ph = PH_PSTART;
            settled = 1'b1;
          end else begin
            ph = PH_LEN;
          end
        end
        PH_PSTART: begin
          if (is_digit(c)) begin
            prc = {24'd0, c - CH_ZERO};
            ph = PH_PDIG;
            settled = 1'b1;
          end else if (c == CH_STAR) begin
            prc = arg;
            ph = PH_LEN;
            settled = 1'b1;
          end else begin
            ph = PH_LEN;
          end
        end
        PH_PDIG: begin
          if (is_digit(c)) begin
            prc = scale_add(prc, c);
            settled = 1'b1;
          end else begin
            ph = PH_LEN;
          end
        end
        PH_LEN: begin
          settled = 1'b1;
          case (c)
            CH_LOW_H: ph = PH_LEN_H;
            CH_LOW_L: ph = PH_LEN_L;
            CH_UP_L: begin
              lenc = LEN_BIGL;
              ph = PH_TYPE;
            end
            CH_LOW_Z: begin
              lenc = LEN_Z;
              ph = PH_TYPE;
            end
            CH_LOW_J: begin
              lenc = LEN_J;
              ph = PH_TYPE;
            end
            default: begin
              ph = PH_TYPE;
              settled = 1'b0;
            end
          endcase
        end
        PH_LEN_H: begin
          ph = PH_TYPE;
          if (c == CH_LOW_H) begin
            lenc = LEN_HH;
            settled = 1'b1;
          end else begin
            lenc = LEN_H;
          end
        end
        PH_LEN_L: begin
          ph = PH_TYPE;
          if (c == CH_LOW_L) begin
            lenc = LEN_LL;
            settled = 1'b1;
          end else begin
            lenc = LEN_L;
          end
        end
        default: begin
          // Type position: an unknown conversion still closes the specifier.
          case (c)
            CH_LOW_C, CH_LOW_S, CH_LOW_P, CH_LOW_D, CH_LOW_I,
            CH_LOW_U, CH_LOW_X, CH_UP_X, CH_PCT: ok = 1'b1;
            default: ok = 1'b0;
          endcase
          res.flags    = flg;
          res.fwidth   = wid;
          res.prec     = prc;
          res.lcode    = lenc;
          res.tchar    = ok ? c : 8'd0;
          res.consumed = ok;
          reset_parser();
          ends = 1'b1;
          settled = 1'b1;
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errs++;
    end
  endtask

  // Track accepted characters and compare every accepted result word.
  always @(posedge clk) begin
    spec_result_t exp_w;
    bit           ends;
    if (!rst_n) begin
      reset_parser();
      expected_specs.delete();
    end else begin
      if (in_valid && !in_stall) begin
        parse_spec_char(in_char_byte, in_star_arg, ends, exp_w);
        if (ends) begin
          expected_specs.push_back(exp_w);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_specs.size() == 0) begin
          $error("result word arrived with no specifier pending");
          errs++;
        end else begin
          exp_w = expected_specs.pop_front();
          check_field("flag_bits", 32'(exp_w.flags), 32'(out_flag_bits));
          check_field("field_width", exp_w.fwidth, out_field_width);
          check_field("precision_value", exp_w.prec, out_precision_value);
          check_field("length_code", 32'(exp_w.lcode), 32'(out_length_code));
          check_field("type_char", 32'(exp_w.tchar), 32'(out_type_char));
          check_field("consumed", 32'(exp_w.consumed), 32'(out_consumed));
        end
      end
    end
    pending_specs  <= expected_specs.size();
    mismatch_count <= errs;
  end

endmodule

/* tb/tb_top.sv */
// Top of the testbench: clock, reset, character stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_top import fsp_pkg::*; ();

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 8'd0;
  logic [31:0] in_star_arg = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_flag_bits;
  logic [31:0] out_field_width;
  logic [31:0] out_precision_value;
  logic [2:0]  out_length_code;
  logic [7:0]  out_type_char;
  logic        out_consumed;

  int pending_specs;
  int mismatch_count;
  int chars_sent = 0;
  int tx_idle_pct = 28;
  int rx_idle_pct = 59;
  int hold_req_cnt = 0;
  int hold_done_cnt = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  format_specifier_parser_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_byte        (in_char_byte),
    .in_star_arg         (in_star_arg),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flag_bits       (out_flag_bits),
    .out_field_width     (out_field_width),
    .out_precision_value (out_precision_value),
    .out_length_code     (out_length_code),
    .out_type_char       (out_type_char),
    .out_consumed        (out_consumed)
  );

  fsp_spec_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_byte        (in_char_byte),
    .in_star_arg         (in_star_arg),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flag_bits       (out_flag_bits),
    .out_field_width     (out_field_width),
    .out_precision_value (out_precision_value),
    .out_length_code     (out_length_code),
    .out_type_char       (out_type_char),
    .out_consumed        (out_consumed),
    .pending_specs       (pending_specs),
    .mismatch_count      (mismatch_count)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_done_cnt) begin
        out_stall <= 1'b1;
        hold_done_cnt <= hold_done_cnt + 1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Star argument with the extremes weighted in.
  function automatic logic [31:0] rnd_arg();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] flag_char(int idx);
    case (idx)
      0: return CH_MINUS;
      1: return CH_PLUS;
      2: return CH_SPACE;
      3: return CH_ZERO;
      4: return CH_APOS;
      default: return CH_HASH;
    endcase
  endfunction

  function automatic logic [7:0] conv_char(int idx);
    case (idx)
      0: return CH_LOW_C;
      1: return CH_LOW_S;
      2: return CH_LOW_P;
      3: return CH_LOW_D;
      4: return CH_LOW_I;
      5: return CH_LOW_U;
      6: return CH_LOW_X;
      7: return CH_UP_X;
      default: return CH_PCT;
    endcase
  endfunction

  // Offers one word after an optional random gap and waits until it is taken.
  task automatic send_char(input logic [7:0] ch, input logic [31:0] arg);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= ch;
    in_star_arg  <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], rnd_arg());
    end
  endtask

  // Decimal digits; long runs push the accumulator into saturation.
  task automatic send_digits(input int first_min);
    int count;
    count = ($urandom_range(7) == 0) ? $urandom_range(12, 9) : $urandom_range(3, 1);
    send_char(CH_ZERO + 8'($urandom_range(9, first_min)), rnd_arg());
    repeat (count - 1) send_char(CH_ZERO + 8'($urandom_range(9)), rnd_arg());
  endtask

  // One well-formed specifier with random content; the type may be bad.
  task automatic send_random_spec();
    int pick;
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(4, 1)) send_char(flag_char($urandom_range(5)), rnd_arg());
    end
    pick = $urandom_range(9);
    if (pick < 4) begin
      send_digits(1);
    end else if (pick < 6) begin
      send_char(CH_STAR, rnd_arg());
    end
    pick = $urandom_range(9);
    if (pick < 5) begin
      send_char(CH_DOT, rnd_arg());
      if (pick < 2) begin
        send_digits(0);
      end else if (pick < 4) begin
        send_char(CH_STAR, rnd_arg());
      end
    end
    case ($urandom_range(11))
      0: send_text("hh");
      1: send_char(CH_LOW_H, rnd_arg());
      2: send_text("ll");
      3: send_char(CH_LOW_L, rnd_arg());
      4: send_char(CH_UP_L, rnd_arg());
      5: send_char(CH_LOW_Z, rnd_arg());
      6: send_char(CH_LOW_J, rnd_arg());
      default: ;
    endcase
    pick = $urandom_range(19);
    if (pick < 16) begin
      send_char(conv_char($urandom_range(8)), rnd_arg());
    end else if (pick == 16) begin
      send_char(8'h00, rnd_arg());
    end else begin
      send_char(8'($urandom_range(255)), rnd_arg());
    end
  endtask

  task automatic run_random(input int target);
    while (chars_sent < target) begin
      if ($urandom_range(9) < 8) begin
        send_random_spec();
      end else begin
        repeat ($urandom_range(4, 1)) send_char(8'($urandom_range(255)), rnd_arg());
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every flag, extreme starred values and a double-letter length.
    send_text("-+ 0'#");
    send_char(CH_STAR, 32'h8000_0000);
    send_char(CH_DOT, rnd_arg());
    send_char(CH_STAR, 32'h7FFF_FFFF);
    send_text("hhd");
    // Saturating width, dot without value, single l followed by a bad type.
    send_text("9999999999.lq");
    // A lone NUL ends the specifier as an invalid type.
    send_char(8'h00, rnd_arg());
    // Length straight from the flag phase, then a length letter as the type.
    send_text("jz");

    // Long receiver hold-off while complete specifiers keep coming.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (24) send_char(CH_LOW_D, rnd_arg());

    tx_idle_pct = 28;
    rx_idle_pct = 59;
    run_random(chars_sent + 280);
    tx_idle_pct = 59;
    rx_idle_pct = 28;
    run_random(chars_sent + 280);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(chars_sent + 240);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_specs != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* format_specifier_parser_unit.f */
+incdir+hw/rtl
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_front.sv
hw/rtl/fsp_queue.sv
hw/rtl/fsp_back.sv
hw/rtl/format_specifier_parser_unit.sv
hw/rtl/fsp_checker.sv
tb/fsp_spec_checker.sv
tb/tb_top.sv
